>>> rtl/dee_pkg.sv
`default_nettype none
package dee_pkg;

	localparam int SYM_W        = 8;
	localparam int DICT_REGS    = 4;
	localparam int DICT_ENTRIES = 16;
	localparam int IDX_W        = 4;
	localparam int REG_W        = 32;
	localparam int CFG_IDX_W    = 8;
	localparam int PEND_W       = 7;
	localparam int CNT_W        = 3;
	localparam int ACC_W        = 16;
	localparam int CODE_W       = 9;

	localparam logic [3:0] LEN_HIT  = 4'd5;
	localparam logic [3:0] LEN_MISS = 4'd9;

	typedef logic [DICT_REGS-1:0][REG_W-1:0] dict_t;

	localparam dict_t DICT_RESET = {
		32'h666D6375, 32'h646C6872, 32'h736E696F, 32'h61746520
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DICT_0_3   = 8'd0,
		REG_DICT_4_7   = 8'd1,
		REG_DICT_8_11  = 8'd2,
		REG_DICT_12_15 = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} match_t;

	typedef struct packed {
		logic [SYM_W-1:0] packed_byte;
		logic             run_last;
		logic             stream_done;
	} word_t;

	// up to two words produced by one symbol
	typedef struct packed {
		logic [1:0] n;
		word_t      w1;
		word_t      w0;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/dee_if.sv
`default_nettype none
interface dee_in_if;
	logic                      valid;
	logic                      ready;
	logic [dee_pkg::SYM_W-1:0] symbol_in;
	logic                      end_of_stream;

	modport source (output valid, output symbol_in, output end_of_stream, input ready);
	modport sink   (input valid, input symbol_in, input end_of_stream, output ready);
endinterface

interface dee_out_if;
	logic                      valid;
	logic                      ready;
	logic [dee_pkg::SYM_W-1:0] packed_byte;
	logic                      run_last;
	logic                      stream_done;

	modport source (output valid, output packed_byte, output run_last, output stream_done,
		input ready);
	modport sink   (input valid, input packed_byte, input run_last, input stream_done,
		output ready);
endinterface

interface dee_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dee_pkg::CFG_IDX_W-1:0] index;
	logic [dee_pkg::REG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/dictionary_escape_encoder_top.sv
`default_nettype none
// Dictionary escape encoder.
// in_ch  : one symbol per word, end_of_stream set on the last symbol of a stream.
// out_ch : packed output bytes, MSB first; run_last marks the last byte caused by
//          a symbol, stream_done the final byte of a stream.
// cfg    : register writes, index 0..3 loads dictionary words (entry 4k in
//          bits 7..0 of word k); other indexes are ignored. Always ready;
//          write only while no symbol is in flight.
// A symbol is registered in the input stage on acceptance, then matched and packed
// combinationally into a two-word output buffer, from which its first byte is
// offered on out_ch. A symbol gives 0 to 2 bytes; the buffer drains one byte per
// cycle while out_ch is ready, so sustained rate is one symbol per cycle while
// symbols give at most one byte; one that gives two waits for room for both.
// Stalls on out_ch hold the buffer; the input stage keeps accepting while the
// buffer has room for the symbol being packed.
// Reset empties the input stage, the buffer and the bit packer, and reloads
// the dictionary with its default contents.
module dictionary_escape_encoder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dee_in_if.sink     in_ch,
	dee_out_if.source  out_ch,
	dee_cfg_if.sink    cfg
);
	import dee_pkg::*;

	dict_t            dict_q;
	logic [SYM_W-1:0] sym_s1;
	logic             eos_s1;
	logic             v_s1;
	match_t           match;
	res_t             res;
	logic [1:0]       space;
	logic             fire;
	logic             in_acc;
	word_t            head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= DICT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_DICT_0_3:   dict_q[0] <= cfg.data;
				REG_DICT_4_7:   dict_q[1] <= cfg.data;
				REG_DICT_8_11:  dict_q[2] <= cfg.data;
				REG_DICT_12_15: dict_q[3] <= cfg.data;
				default:        dict_q    <= dict_q;
			endcase
		end
	end

	assign fire         = v_s1 && (res.n <= space);
	assign in_ch.ready  = !v_s1 || fire;
	assign in_acc       = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_s1 <= in_ch.symbol_in;
			eos_s1 <= in_ch.end_of_stream;
		end
	end

	dee_match u_match (
		.dict  (dict_q),
		.sym   (sym_s1),
		.match (match)
	);

	dee_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym_s1),
		.eos    (eos_s1),
		.match  (match),
		.fire   (fire),
		.res    (res)
	);

	dee_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.push   (fire),
		.space  (space),
		.valid  (out_ch.valid),
		.ready  (out_ch.ready),
		.head   (head)
	);

	assign out_ch.packed_byte = head.packed_byte;
	assign out_ch.run_last    = head.run_last;
	assign out_ch.stream_done = head.stream_done;

endmodule
`default_nettype wire

>>> rtl/dee_match.sv
`default_nettype none
module dee_match (
	input  wire dee_pkg::dict_t                dict,
	input  wire logic [dee_pkg::SYM_W-1:0]     sym,
	output dee_pkg::match_t                    match
);
	import dee_pkg::*;

	always_comb begin
		match = '0;
		// walk downwards so the lowest matching entry is kept
		for (int d = DICT_ENTRIES - 1; d >= 0; d--) begin
			if (dict[d / 4][8 * (d % 4) +: SYM_W] == sym) begin
				match.hit = 1'b1;
				match.idx = IDX_W'(d);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/dee_pack.sv
`default_nettype none
module dee_pack (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [dee_pkg::SYM_W-1:0] sym,
	input  wire logic                      eos,
	input  wire dee_pkg::match_t           match,
	input  wire logic                      fire,
	output dee_pkg::res_t                  res
);
	import dee_pkg::*;

	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [3:0]        len;
	logic [CODE_W-1:0] code;
	logic [ACC_W-1:0]  acc;
	logic [4:0]        total;
	logic [CNT_W-1:0]  rem;
	logic [1:0]        nb;
	logic              pad;
	logic [SYM_W-1:0]  pad_byte;
	logic [SYM_W-1:0]  mask;
	logic [PEND_W-1:0] keep;

	always_comb begin
		len      = match.hit ? LEN_HIT : LEN_MISS;
		code     = match.hit ? {4'b0, 1'b1, match.idx} : {1'b0, sym};
		acc      = (ACC_W'(pend_q) << len) | ACC_W'(code);
		total    = 5'({2'b0, cnt_q}) + 5'({1'b0, len});
		rem      = total[2:0];
		nb       = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
		pad      = eos && (rem != '0);
		pad_byte = SYM_W'(acc << (4'd8 - {1'b0, rem}));
		mask     = (8'd1 << rem) - 8'd1;
		keep     = PEND_W'(acc) & PEND_W'(mask);

		res      = '0;
		res.n    = nb + {1'b0, pad};
		unique case (nb)
			2'd2: begin
				res.w0.packed_byte = acc[15:8];
				res.w1.packed_byte = acc[7:0];
			end
			2'd1: begin
				res.w0.packed_byte = SYM_W'(acc >> rem);
				res.w1.packed_byte = pad_byte;
			end
			default: begin
				res.w0.packed_byte = pad_byte;
				res.w1.packed_byte = '0;
			end
		endcase
		if (res.n == 2'd2) begin
			res.w1.run_last    = 1'b1;
			res.w1.stream_done = eos;
		end else begin
			res.w0.run_last    = 1'b1;
			res.w0.stream_done = eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			pend_q <= eos ? '0 : keep;
			cnt_q  <= eos ? '0 : rem;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dee_obuf.sv
`default_nettype none
module dee_obuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dee_pkg::res_t  res,
	input  wire logic           push,
	output logic [1:0]          space,
	output logic                valid,
	input  wire logic           ready,
	output dee_pkg::word_t      head
);
	import dee_pkg::*;

	word_t      d0_q;
	word_t      d1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] rc;
	word_t      r0;
	logic [1:0] add;

	always_comb begin
		valid = (cnt_q != 2'd0);
		head  = d0_q;
		pop   = valid && ready;
		rc    = cnt_q - {1'b0, pop};
		r0    = pop ? d1_q : d0_q;
		space = 2'd2 - rc;
		add   = push ? res.n : 2'd0;
	end

	always_ff @(posedge clk) begin
		case (rc)
			2'd0: begin
				d0_q <= res.w0;
				d1_q <= res.w1;
			end
			2'd1: begin
				d0_q <= r0;
				d1_q <= res.w0;
			end
			default: begin
				d0_q <= d0_q;
				d1_q <= d1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= rc + add;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dee_checker.sv
`default_nettype none
module dee_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last,
	input wire logic       out_done
);

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) && $stable(out_done))
		else $error("output word changed while stalled");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_done || out_last)
		else $error("stream_done without run_last");

	// a symbol yields at most two bytes, so two non-final bytes never follow each other
	a_no_two_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !out_last |=> !(out_acc && !out_last))
		else $error("more than two bytes for one symbol");

endmodule

bind dictionary_escape_encoder_top dee_checker u_dee_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.packed_byte),
	.out_last  (out_ch.run_last),
	.out_done  (out_ch.stream_done)
);
`default_nettype wire
